@@ rtl/core/rxff_pkg.sv @@
// ============================================================================
// rxff_pkg
// Shared types, constants and helpers of the receive frame filter.
// ============================================================================
`default_nettype none

package rxff_pkg;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int MAC_W    = 48;
    localparam int TYPE_W   = 16;
    localparam int LEN_W    = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = MAC_W;

    // Record layout: a two-byte length prefix, then the frame header.
    localparam int PREFIX_BYTES = 2;
    localparam int MAC_BYTES    = 6;
    localparam int HDR_TYPE_OFS = 12;
    localparam int HDR_SIZE_OFS = 14;

    // Record byte positions (prefix included).
    localparam logic [LEN_W-1:0] POS_LEN_HI    = LEN_W'(0);
    localparam logic [LEN_W-1:0] POS_LEN_LO    = LEN_W'(1);
    localparam logic [LEN_W-1:0] POS_DST_FIRST = LEN_W'(PREFIX_BYTES);
    localparam logic [LEN_W-1:0] POS_DST_LAST  = LEN_W'(PREFIX_BYTES + MAC_BYTES - 1);
    localparam logic [LEN_W-1:0] POS_TYPE_HI   = LEN_W'(PREFIX_BYTES + HDR_TYPE_OFS);
    localparam logic [LEN_W-1:0] POS_TYPE_LO   = LEN_W'(PREFIX_BYTES + HDR_TYPE_OFS + 1);
    localparam logic [LEN_W-1:0] POS_SIZE_HI   = LEN_W'(PREFIX_BYTES + HDR_SIZE_OFS);
    localparam logic [LEN_W-1:0] POS_SIZE_LO   = LEN_W'(PREFIX_BYTES + HDR_SIZE_OFS + 1);
    localparam logic [LEN_W-1:0] POS_MAX       = {LEN_W{1'b1}};

    localparam logic [BYTE_W-1:0] BCAST_BYTE   = 8'hFF;
    localparam logic [15:0]       MTU_RESET    = 16'd1498;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_OWN_MAC    = 2'd0,
        CFG_ETHER_TYPE = 2'd1,
        CFG_MTU_LIMIT  = 2'd2
    } cfg_addr_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DEST  = 2'd1,
        ST_BAD_TYPE  = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    // One result item.
    typedef struct packed {
        status_t          status;
        logic [LEN_W-1:0] frame_length;
        logic [LEN_W-1:0] payload_length;
    } rec_result_t;

    // Byte of the station MAC for destination byte idx (0 = first sent).
    function automatic logic [BYTE_W-1:0] mac_byte(input logic [MAC_W-1:0] mac,
                                                   input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            3'd5:    b = mac[7:0];
            default: b = '0;
        endcase
        return b;
    endfunction

    // Value minus two, floored at zero.
    function automatic logic [LEN_W-1:0] minus_two(input logic [LEN_W-1:0] v);
        return (v >= LEN_W'(2)) ? (v - LEN_W'(2)) : '0;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ethernet_rx_frame_filter_top.sv @@
// A result item is registered as its record's last byte leaves the input register.
// Throughput: one byte per cycle; the input register and the result register
// decouple the two channels, so bytes keep flowing while a result waits.
// Only a record's last byte can stall, and only while a result is untaken.
// Reset (aresetn, synchronous, active low) empties both registers, clears the
// record state and sets own_mac and ether_type to 0 and mtu_limit to 1498.
// ============================================================================
// ethernet_rx_frame_filter_top
// Receive destination and ethertype filter with a length check.
// ============================================================================
`default_nettype none

module ethernet_rx_frame_filter_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input byte channel.
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [rxff_pkg::BYTE_W-1:0]       s_data_byte,
    input  wire logic                              s_last,
    // Result channel.
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [1:0]                             m_status,
    output logic [rxff_pkg::LEN_W-1:0]             m_frame_length,
    output logic [rxff_pkg::LEN_W-1:0]             m_payload_length,
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rxff_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [rxff_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rxff_pkg::*;

    logic [MAC_W-1:0]  own_mac_reg;
    logic [TYPE_W-1:0] ether_type_reg;
    logic [LEN_W-1:0]  mtu_limit_reg;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    logic              m_valid_reg;
    rec_result_t       out_reg;
    rec_result_t       hdr_result;

    logic              advance;
    logic              out_load;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg    <= '0;
            ether_type_reg <= '0;
            mtu_limit_reg  <= MTU_RESET;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_OWN_MAC:    own_mac_reg    <= cfg_data;
                CFG_ETHER_TYPE: ether_type_reg <= cfg_data[TYPE_W-1:0];
                CFG_MTU_LIMIT:  mtu_limit_reg  <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // The held byte moves on unless it ends a record and the result is still untaken.
    assign out_load = advance && in_last_reg;
    assign advance  = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last;
        end
    end

    // Header tracking and result logic.
    rxff_hdr u_hdr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .data_byte  (in_byte_reg),
        .last       (in_last_reg),
        .own_mac    (own_mac_reg),
        .ether_type (ether_type_reg),
        .mtu_limit  (mtu_limit_reg),
        .result     (hdr_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= hdr_result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = out_reg.status;
    assign m_frame_length   = out_reg.frame_length;
    assign m_payload_length = out_reg.payload_length;

    // A held byte that cannot move on stays in the input register unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
                                     && $stable(in_last_reg))
        else $error("input register lost a stalled item");

    // A new item is only taken into an empty or draining input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && in_valid_reg |-> advance)
        else $error("input register overwritten");

    // The result register is never reloaded while its item is still untaken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && m_valid_reg |-> m_ready)
        else $error("result item overwritten before it was taken");

    // The payload length, a size field minus two, stays at or below POS_MAX minus two.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> out_reg.payload_length <= (POS_MAX - LEN_W'(2)))
        else $error("payload length out of range");

endmodule

`default_nettype wire

@@ rtl/core/rxff_hdr.sv @@
// ============================================================================
// rxff_hdr
// Per-record header tracker: position count, prefix and size capture,
// destination and ethertype match flags, and the result of the last byte.
// ============================================================================
`default_nettype none

module rxff_hdr (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step,
    input  wire logic [rxff_pkg::BYTE_W-1:0]   data_byte,
    input  wire logic                          last,
    input  wire logic [rxff_pkg::MAC_W-1:0]    own_mac,
    input  wire logic [rxff_pkg::TYPE_W-1:0]   ether_type,
    input  wire logic [rxff_pkg::LEN_W-1:0]    mtu_limit,
    output rxff_pkg::rec_result_t              result
);
    import rxff_pkg::*;

    logic [LEN_W-1:0] pos_reg,    pos_next;
    logic [LEN_W-1:0] prefix_reg, prefix_next;
    logic [LEN_W-1:0] size_reg,   size_next;
    logic             own_reg,    own_next;
    logic             bcast_reg,  bcast_next;
    logic             type_reg,   type_next;
    logic [2:0]       dst_idx;
    logic [LEN_W-1:0] flen;
    logic             dest_full;
    logic             type_full;

    // Fold the current byte into the record fields.
    always_comb begin
        prefix_next = prefix_reg;
        size_next   = size_reg;
        own_next    = own_reg;
        bcast_next  = bcast_reg;
        type_next   = type_reg;
        dst_idx     = pos_reg[2:0] - 3'(PREFIX_BYTES);

        if (pos_reg == POS_LEN_HI) begin
            prefix_next[15:8] = data_byte;
        end else if (pos_reg == POS_LEN_LO) begin
            prefix_next[7:0] = data_byte;
        end else if (pos_reg >= POS_DST_FIRST && pos_reg <= POS_DST_LAST) begin
            if (data_byte != mac_byte(own_mac, dst_idx)) begin
                own_next = 1'b0;
            end
            if (data_byte != BCAST_BYTE) begin
                bcast_next = 1'b0;
            end
        end else if (pos_reg == POS_TYPE_HI) begin
            if (data_byte != ether_type[15:8]) begin
                type_next = 1'b0;
            end
        end else if (pos_reg == POS_TYPE_LO) begin
            if (data_byte != ether_type[7:0]) begin
                type_next = 1'b0;
            end
        end else if (pos_reg == POS_SIZE_HI) begin
            size_next[15:8] = data_byte;
        end else if (pos_reg == POS_SIZE_LO) begin
            size_next[7:0] = data_byte;
        end

        pos_next = (pos_reg != POS_MAX) ? pos_reg + LEN_W'(1) : pos_reg;
    end

    // Result for a record ending on the current byte, in priority order.
    always_comb begin
        flen      = minus_two(prefix_next);
        dest_full = (pos_reg >= POS_DST_LAST);
        type_full = (pos_reg >= POS_TYPE_LO);

        if (!dest_full || (!own_next && !bcast_next)) begin
            result.status = ST_BAD_DEST;
        end else if (!type_full || !type_next) begin
            result.status = ST_BAD_TYPE;
        end else if (flen > mtu_limit) begin
            result.status = ST_TRUNCATED;
        end else begin
            result.status = ST_OK;
        end
        result.frame_length   = flen;
        result.payload_length = minus_two(size_next);
    end

    // Record state; the last byte returns it to the start of a record.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last)) begin
            pos_reg    <= '0;
            prefix_reg <= '0;
            size_reg   <= '0;
            own_reg    <= 1'b1;
            bcast_reg  <= 1'b1;
            type_reg   <= 1'b1;
        end else if (step) begin
            pos_reg    <= pos_next;
            prefix_reg <= prefix_next;
            size_reg   <= size_next;
            own_reg    <= own_next;
            bcast_reg  <= bcast_next;
            type_reg   <= type_next;
        end
    end

    // A record that ended leaves the tracker at its start.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && last |=> pos_reg == '0 && own_reg && bcast_reg && type_reg)
        else $error("rxff_hdr: record state not cleared after last byte");

    // The byte position holds at its top value instead of wrapping.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && !last && pos_reg == POS_MAX |=> pos_reg == POS_MAX)
        else $error("rxff_hdr: byte position wrapped");

    // A destination mismatch stays recorded until the record ends.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !own_reg && !(step && last) |=> !own_reg)
        else $error("rxff_hdr: destination mismatch lost within a record");

endmodule

`default_nettype wire

@@ tb/sv/ethernet_rx_frame_filter_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ethernet_rx_frame_filter_checker
// Watches the byte, result and register channels of the receive frame filter,
// predicts the status item of every record and compares it field by field.
// ============================================================================

module ethernet_rx_frame_filter_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [rxff_pkg::BYTE_W-1:0]     s_data_byte,
    input  logic                            s_last,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [1:0]                      m_status,
    input  logic [rxff_pkg::LEN_W-1:0]      m_frame_length,
    input  logic [rxff_pkg::LEN_W-1:0]      m_payload_length,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rxff_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rxff_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              error_count,
    output int                              outstanding
);
    import rxff_pkg::*;

    // Register copies.
    logic [MAC_W-1:0]  station_mac;
    logic [TYPE_W-1:0] wanted_type;
    logic [LEN_W-1:0]  mtu;

    // Per-record state.
    logic [LEN_W-1:0]  rec_pos;
    logic [LEN_W-1:0]  rec_prefix;
    logic              own_ok;
    logic              bcast_ok;
    logic              type_ok;
    logic [LEN_W-1:0]  rec_size;

    // Status items still owed by the block, oldest first.
    rec_result_t filter_verdicts[$];

    function automatic logic [LEN_W-1:0] less_two(input logic [LEN_W-1:0] v);
        return (v > 16'd1) ? v - 16'd2 : 16'd0;
    endfunction

    task automatic start_record();
        rec_pos    = '0;
        rec_prefix = '0;
        own_ok     = 1'b1;
        bcast_ok   = 1'b1;
        type_ok    = 1'b1;
        rec_size   = '0;
    endtask

    // Advance the record state by one byte; a last byte yields a status item.
    task automatic filter_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        logic [LEN_W-1:0] at;
        int               fo;
        rec_result_t      verdict;
        at = rec_pos;
        if (at == POS_LEN_HI) begin
            rec_prefix[15:8] = b;
        end else if (at == POS_LEN_LO) begin
            rec_prefix[7:0] = b;
        end else begin
            fo = int'(at) - PREFIX_BYTES;
            if (fo < MAC_BYTES) begin
                if (b != station_mac[47 - 8*fo -: 8]) own_ok = 1'b0;
                if (b != BCAST_BYTE) bcast_ok = 1'b0;
            end else if (fo == HDR_TYPE_OFS) begin
                if (b != wanted_type[15:8]) type_ok = 1'b0;
            end else if (fo == HDR_TYPE_OFS + 1) begin
                if (b != wanted_type[7:0]) type_ok = 1'b0;
            end else if (fo == HDR_SIZE_OFS) begin
                rec_size[15:8] = b;
            end else if (fo == HDR_SIZE_OFS + 1) begin
                rec_size[7:0] = b;
            end
        end
        if (rec_pos != POS_MAX) rec_pos = rec_pos + 16'd1;

        if (is_last) begin
            verdict.frame_length   = less_two(rec_prefix);
            verdict.payload_length = less_two(rec_size);
            // A destination or ethertype cut short counts as a mismatch.
            if (at < POS_DST_LAST || (!own_ok && !bcast_ok))
                verdict.status = ST_BAD_DEST;
            else if (at < POS_TYPE_LO || !type_ok)
                verdict.status = ST_BAD_TYPE;
            else if (verdict.frame_length > mtu)
                verdict.status = ST_TRUNCATED;
            else
                verdict.status = ST_OK;
            filter_verdicts.push_back(verdict);
            start_record();
        end
    endtask

    always @(posedge aclk) begin : watch
        rec_result_t want;
        if (!aresetn) begin
            station_mac = '0;
            wanted_type = '0;
            mtu         = MTU_RESET;
            start_record();
            filter_verdicts.delete();
        end else begin
            // Register writes; indexes past the list are ignored.
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_OWN_MAC:    station_mac = cfg_data[MAC_W-1:0];
                    CFG_ETHER_TYPE: wanted_type = cfg_data[TYPE_W-1:0];
                    CFG_MTU_LIMIT:  mtu = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end

            // Compare each taken result item with the oldest prediction.
            if (m_valid && m_ready) begin
                if (filter_verdicts.size() == 0) begin
                    if (error_count < 10)
                        $display("%0t: unexpected result item status %0d len %0d size %0d",
                                 $realtime, m_status, m_frame_length, m_payload_length);
                    error_count++;
                end else begin
                    want = filter_verdicts.pop_front();
                    if (want.status != m_status || want.frame_length != m_frame_length ||
                        want.payload_length != m_payload_length) begin
                        if (error_count < 10) begin
                            $display("%0t: result mismatch: status exp %0d got %0d",
                                     $realtime, want.status, m_status);
                            $display("    frame_length exp %0d got %0d",
                                     want.frame_length, m_frame_length);
                            $display("    payload_length exp %0d got %0d",
                                     want.payload_length, m_payload_length);
                        end
                        error_count++;
                    end
                end
            end

            if (s_valid && s_ready) filter_byte(s_data_byte, s_last);
        end
        outstanding = filter_verdicts.size();
    end

endmodule

@@ tb/sv/ethernet_rx_frame_filter_top_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ethernet_rx_frame_filter_top_tb
// Sends directed and random receive records through the frame filter with
// random idle gaps and result stalls, across several register settings.
// ============================================================================

module ethernet_rx_frame_filter_top_tb;
    import rxff_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BYTES = 1000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_data_byte;
    logic                  s_last;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_status;
    logic [LEN_W-1:0]      m_frame_length;
    logic [LEN_W-1:0]      m_payload_length;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    int error_count;
    int outstanding;
    int cycle_count;
    int bytes_sent;
    bit no_gaps;

    // Settings currently loaded, used to aim the random records.
    logic [MAC_W-1:0]  cur_own;
    logic [TYPE_W-1:0] cur_type;
    logic [LEN_W-1:0]  cur_mtu;

    // Bytes of the record being sent.
    logic [BYTE_W-1:0] rec_bytes[$];

    ethernet_rx_frame_filter_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_frame_length   (m_frame_length),
        .m_payload_length (m_payload_length),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_addr         (cfg_addr),
        .cfg_data         (cfg_data)
    );

    ethernet_rx_frame_filter_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_frame_length   (m_frame_length),
        .m_payload_length (m_payload_length),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_addr         (cfg_addr),
        .cfg_data         (cfg_data),
        .error_count      (error_count),
        .outstanding      (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Runaway guard.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_cycles();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        return {16'($urandom), $urandom};
    endfunction

    // Result side: ready stretches broken by stalls of random length.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_ready = 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(50, 200)) @(negedge aclk);
            else
                repeat ($urandom_range(0, 20)) @(negedge aclk);
            stall = $urandom_range(0, 99);
            if (stall < 30) stall = 0;
            else if (stall < 80) stall = $urandom_range(1, 3);
            else if (stall < 95) stall = $urandom_range(4, 12);
            else stall = $urandom_range(20, 80);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    // Offer one byte and hold it until the block takes it.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_data_byte = b;
        s_last      = is_last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_record();
        for (int i = 0; i < rec_bytes.size(); i++)
            send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
    endtask

    // Stop sending and let the block drain before touching a register.
    task automatic await_idle();
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_addr  = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_settings(input logic [MAC_W-1:0] own, input logic [TYPE_W-1:0] et,
                                 input logic [LEN_W-1:0] lim);
        cur_own  = own;
        cur_type = et;
        cur_mtu  = lim;
        cfg_write(CFG_OWN_MAC, own);
        cfg_write(CFG_ETHER_TYPE, 48'(et));
        cfg_write(CFG_MTU_LIMIT, 48'(lim));
    endtask

    // Build a record: prefix, header, payload. keep < 0 sends it whole,
    // prefix < 0 makes the prefix the number of bytes actually sent.
    task automatic build_record(input logic [MAC_W-1:0] dst, input logic [TYPE_W-1:0] et,
                                input logic [LEN_W-1:0] sz, input int pay_len,
                                input int keep, input int prefix);
        logic [LEN_W-1:0] pv;
        rec_bytes = {};
        rec_bytes.push_back(8'h00);
        rec_bytes.push_back(8'h00);
        for (int i = 0; i < MAC_BYTES; i++) rec_bytes.push_back(dst[47 - 8*i -: 8]);
        repeat (MAC_BYTES) rec_bytes.push_back(8'($urandom));
        rec_bytes.push_back(et[15:8]);
        rec_bytes.push_back(et[7:0]);
        rec_bytes.push_back(sz[15:8]);
        rec_bytes.push_back(sz[7:0]);
        repeat (pay_len) rec_bytes.push_back(8'($urandom));
        if (keep > 0)
            while (rec_bytes.size() > keep) void'(rec_bytes.pop_back());
        pv = (prefix < 0) ? LEN_W'(rec_bytes.size()) : prefix[15:0];
        rec_bytes[0] = pv[15:8];
        if (rec_bytes.size() > 1) rec_bytes[1] = pv[7:0];
    endtask

    task automatic directed(input logic [MAC_W-1:0] dst, input logic [TYPE_W-1:0] et,
                            input logic [LEN_W-1:0] sz, input int pay_len,
                            input int keep, input int prefix);
        build_record(dst, et, sz, pay_len, keep, prefix);
        send_record();
    endtask

    // Random register settings, extremes included.
    task automatic pick_settings();
        logic [MAC_W-1:0]  own;
        logic [TYPE_W-1:0] et;
        logic [LEN_W-1:0]  lim;
        case ($urandom_range(0, 4))
            0:       own = '0;
            1:       own = '1;
            default: own = rand_mac();
        endcase
        case ($urandom_range(0, 4))
            0:       et = '0;
            1:       et = '1;
            2:       et = 16'h0800;
            default: et = 16'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       lim = MTU_RESET;
            1:       lim = '0;
            2:       lim = '1;
            3, 4:    lim = LEN_W'($urandom_range(10, 60));
            default: lim = 16'($urandom);
        endcase
        load_settings(own, et, lim);
        if ($urandom_range(0, 4) == 0) cfg_write(CFG_SPARE, rand_mac());
    endtask

    // Mostly well-formed records aimed at the current settings, some noise.
    task automatic make_random_record();
        logic [MAC_W-1:0]  dst;
        logic [TYPE_W-1:0] et;
        logic [LEN_W-1:0]  sz;
        int pay, keep, pfx, r;
        if ($urandom_range(0, 99) < 6) begin
            rec_bytes = {};
            repeat ($urandom_range(1, 30)) rec_bytes.push_back(8'($urandom));
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 45) dst = cur_own;
        else if (r < 70) dst = '1;
        else if (r < 85) dst = cur_own ^ (48'd1 << $urandom_range(0, 47));
        else dst = rand_mac();
        et = ($urandom_range(0, 99) < 75) ? cur_type : cur_type ^ (16'd1 << $urandom_range(0, 15));
        sz = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 2)) : 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 80) pay = $urandom_range(0, 10);
        else if (r < 97) pay = $urandom_range(11, 60);
        else pay = $urandom_range(61, 150);
        keep = ($urandom_range(0, 99) < 85) ? -1 : $urandom_range(1, 20);
        r = $urandom_range(0, 99);
        if (r < 65) pfx = -1;
        else if (r < 80) pfx = $urandom_range(0, 65535);
        else if (r < 90) pfx = (int'(cur_mtu) + 2 + $urandom_range(0, 1)) & 16'hFFFF;
        else pfx = $urandom_range(0, 3);
        build_record(dst, et, sz, pay, keep, pfx);
    endtask

    initial begin
        logic [MAC_W-1:0] mac;
        int base, records;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        s_last      = 1'b0;
        cfg_valid   = 1'b0;
        cfg_addr    = CFG_OWN_MAC;
        cfg_data    = '0;
        bytes_sent  = 0;
        no_gaps     = 1'b0;
        cur_own     = '0;
        cur_type    = '0;
        cur_mtu     = MTU_RESET;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset settings: limit edge, size field extremes, records cut short.
        directed('0, '0, 16'h0000, 0, -1, 1500);
        directed('0, '0, 16'hFFFF, 0, -1, 1501);
        directed('0, '0, 16'h1234, 0, 1, -1);
        directed('0, '0, 16'h1234, 0, 2, 1);
        directed('0, '0, 16'h1234, 0, 7, -1);
        directed('0, '0, 16'h1234, 0, 8, -1);
        directed('0, '0, 16'h1234, 0, 15, -1);
        directed('0, '0, 16'h1234, 0, 16, -1);
        directed('0, '0, 16'h1234, 0, 17, -1);

        // Station address, a common ethertype, and a write past the list.
        await_idle();
        mac = rand_mac();
        load_settings(mac, 16'h0800, 16'd1500);
        cfg_write(CFG_SPARE, '1);
        directed('1, 16'h0800, 16'd64, 3, -1, -1);
        directed(mac ^ 48'h01, 16'h0800, 16'd64, 3, -1, -1);
        directed(mac ^ 48'h8000_0000_0000, 16'h0801, 16'd64, 3, -1, -1);
        directed(mac, 16'h8800, 16'd64, 3, -1, 16'hFFFF);
        directed(mac, 16'h0800, 16'd64, 3, -1, 0);
        directed('1, 16'h0800, 16'd1, 0, -1, -1);
        directed(mac, 16'h0800, 16'd40, 30, -1, 20);

        // Station address equal to broadcast, zero limit.
        await_idle();
        load_settings('1, '1, '0);
        directed('1, '1, 16'd2, 0, -1, 2);
        directed('1, '1, 16'd3, 0, -1, 3);

        // Widest limit.
        await_idle();
        load_settings('0, '0, '1);
        directed('0, '0, 16'hFFFF, 0, -1, 16'hFFFF);

        // Random records, with new settings every dozen records.
        base    = bytes_sent;
        records = 0;
        while (bytes_sent - base < RANDOM_BYTES) begin
            if (records % 12 == 0) begin
                await_idle();
                pick_settings();
            end
            no_gaps = ($urandom_range(0, 4) == 0);
            make_random_record();
            send_record();
            records++;
        end

        // Drain and give the verdict.
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/rxff_pkg.sv
rtl/core/rxff_hdr.sv
rtl/core/ethernet_rx_frame_filter_top.sv
tb/sv/ethernet_rx_frame_filter_checker.sv
tb/sv/ethernet_rx_frame_filter_top_tb.sv
